FILE: rtl/core/dtpc_pkg.sv
// shared types and constants for the depth to point cloud converter
`default_nettype none

package dtpc_pkg;

    // field widths
    localparam int DEPTH_W    = 16;
    localparam int Z_W        = 26;
    localparam int XY_W       = 36;
    localparam int CFG_DIM_W  = 12;
    localparam int SCALE_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // defaults and fixed scaling
    localparam int DEF_MAX_DIM     = 2048;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int UM_PER_MM       = 1000;

    // register reset values
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [SCALE_W-1:0]   RST_PIXEL_SCALE  = 24'd29140;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE  = 2'd2;

    // saturation limits of x and y
    localparam logic signed [XY_W-1:0] XY_MAX = {1'b0, {(XY_W-1){1'b1}}};
    localparam logic signed [XY_W-1:0] XY_MIN = {1'b1, {(XY_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MZ,
        ST_MXL,
        ST_MXH,
        ST_SX,
        ST_MYL,
        ST_MYH,
        ST_SY,
        ST_FIN
    } state_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ZS,
        MUL_XLO,
        MUL_XHI,
        MUL_YLO,
        MUL_YHI
    } mul_op_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    sum_x;
        logic    sum_y;
        logic    finish;
    } cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/dtpc_if.sv
// request channels of the depth to point cloud converter
`default_nettype none

interface dtpc_depth_if;
    logic                          valid;
    logic                          ready;
    logic [dtpc_pkg::DEPTH_W-1:0]  depth_mm;

    modport source (output valid, output depth_mm, input ready);
    modport sink   (input valid, input depth_mm, output ready);
endinterface

interface dtpc_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [dtpc_pkg::XY_W-1:0]  x_um;
    logic signed [dtpc_pkg::XY_W-1:0]  y_um;
    logic [dtpc_pkg::Z_W-1:0]          z_um;
    logic                              frame_last;

    modport source (output valid, output x_um, output y_um, output z_um, output frame_last,
                    input ready);
    modport sink   (input valid, input x_um, input y_um, input z_um, input frame_last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dtpc_ctrl.sv
// sequencer for the depth to point cloud converter
`default_nettype none

module dtpc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dtpc_pkg::sts_t sts,
    output dtpc_pkg::cmd_t      cmd
);

    dtpc_pkg::state_t state_reg;
    dtpc_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = dtpc_pkg::MUL_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            dtpc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dtpc_pkg::ST_MZ;
                end
            end
            dtpc_pkg::ST_MZ:
            begin
                cmd.mul_op = dtpc_pkg::MUL_ZS;
                state_next = dtpc_pkg::ST_MXL;
            end
            dtpc_pkg::ST_MXL:
            begin
                cmd.mul_op = dtpc_pkg::MUL_XLO;
                state_next = dtpc_pkg::ST_MXH;
            end
            dtpc_pkg::ST_MXH:
            begin
                cmd.mul_op = dtpc_pkg::MUL_XHI;
                state_next = dtpc_pkg::ST_SX;
            end
            dtpc_pkg::ST_SX:
            begin
                cmd.sum_x  = 1'b1;
                state_next = dtpc_pkg::ST_MYL;
            end
            dtpc_pkg::ST_MYL:
            begin
                cmd.mul_op = dtpc_pkg::MUL_YLO;
                state_next = dtpc_pkg::ST_MYH;
            end
            dtpc_pkg::ST_MYH:
            begin
                cmd.mul_op = dtpc_pkg::MUL_YHI;
                state_next = dtpc_pkg::ST_SY;
            end
            dtpc_pkg::ST_SY:
            begin
                cmd.sum_y  = 1'b1;
                state_next = dtpc_pkg::ST_FIN;
            end
            dtpc_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = dtpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtpc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // an accepted request always starts the z times scale product
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == dtpc_pkg::ST_MZ))
        else $error("accepted request did not start the multiply sequence");

    // a result waiting on a full output slot is held, not dropped
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtpc_pkg::ST_FIN && !sts.out_free) |=> (state_reg == dtpc_pkg::ST_FIN))
        else $error("finished point left the final state while output was busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dtpc_dpath.sv
// datapath: raster counters, shared multiplier, rounding and saturation
`default_nettype none

module dtpc_dpath #(
    parameter int MAX_DIM = dtpc_pkg::DEF_MAX_DIM
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dtpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dtpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [dtpc_pkg::DEPTH_W-1:0]        depth_mm,
    input  wire dtpc_pkg::cmd_t                      cmd,
    output dtpc_pkg::sts_t                           sts,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed [dtpc_pkg::XY_W-1:0]         x_um,
    output logic signed [dtpc_pkg::XY_W-1:0]         y_um,
    output logic [dtpc_pkg::Z_W-1:0]                 z_um,
    output logic                                     frame_last
);

    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int EFF_W   = $clog2(MAX_DIM + 1);
    localparam int CNT1_W  = DIM_W + 1;
    localparam int ZS_W    = dtpc_pkg::Z_W + dtpc_pkg::SCALE_W;
    localparam int LO_W    = ZS_W / 2;
    localparam int HI_W    = ZS_W - LO_W;
    localparam int MUL_A_W = (dtpc_pkg::Z_W > HI_W) ? dtpc_pkg::Z_W : HI_W;
    localparam int MUL_B_W = (dtpc_pkg::SCALE_W > DIM_W) ? dtpc_pkg::SCALE_W : DIM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int PLO_W   = LO_W + DIM_W;
    localparam int PHI_W   = HI_W + DIM_W;
    localparam int MAG_W   = ZS_W + DIM_W;

    // configuration registers
    logic [dtpc_pkg::CFG_DIM_W-1:0] fw_reg;
    logic [dtpc_pkg::CFG_DIM_W-1:0] fh_reg;
    logic [dtpc_pkg::SCALE_W-1:0]   scale_reg;

    // raster position
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;

    // per-pixel operands
    logic [dtpc_pkg::Z_W-1:0] z_reg;
    logic [DIM_W-1:0]         dx_reg;
    logic [DIM_W-1:0]         dy_reg;
    logic                     neg_x_reg;
    logic                     neg_y_reg;
    logic                     last_reg;

    // products and sums
    logic [ZS_W-1:0]  zs_reg;
    logic [PLO_W-1:0] plo_reg;
    logic [PHI_W-1:0] phi_reg;
    logic [MAG_W-1:0] mag_x_reg;
    logic [MAG_W-1:0] mag_y_reg;

    // output slot
    logic                             out_valid_reg;
    logic signed [dtpc_pkg::XY_W-1:0] x_out_reg;
    logic signed [dtpc_pkg::XY_W-1:0] y_out_reg;
    logic [dtpc_pkg::Z_W-1:0]         z_out_reg;
    logic                             last_out_reg;

    logic [EFF_W-1:0]   w_eff;
    logic [EFF_W-1:0]   h_eff;
    logic [CNT1_W-1:0]  w_ext;
    logic [CNT1_W-1:0]  h_ext;
    logic [CNT1_W-1:0]  u_inc;
    logic [CNT1_W-1:0]  v_inc;
    logic               row_end;
    logic               frame_end;
    logic [DIM_W-1:0]   cu;
    logic [DIM_W-1:0]   cv;
    logic               neg_x;
    logic               neg_y;
    logic [DIM_W-1:0]   dx;
    logic [DIM_W-1:0]   dy;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [MAG_W-1:0]   mag_sum;

    // clamp a configured size into 1..MAX_DIM
    function automatic logic [EFF_W-1:0] eff_dim(input logic [dtpc_pkg::CFG_DIM_W-1:0] d);
        logic [EFF_W-1:0] r;
        if (d == '0)
        begin
            r = EFF_W'(1);
        end
        else if (32'(d) > 32'(MAX_DIM))
        begin
            r = EFF_W'(MAX_DIM);
        end
        else
        begin
            r = EFF_W'(d);
        end
        return r;
    endfunction

    // floor of the signed product over 2^frac, saturated to the output range
    function automatic logic signed [dtpc_pkg::XY_W-1:0] to_um(input logic [MAG_W-1:0] mag,
                                                                 input logic neg);
        logic signed [MAG_W:0]            s;
        logic signed [MAG_W:0]            t;
        logic [MAG_W-dtpc_pkg::XY_W+1:0]  top;
        logic signed [dtpc_pkg::XY_W-1:0] r;
        s   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        t   = s >>> dtpc_pkg::SCALE_FRAC_BITS;
        top = t[MAG_W:dtpc_pkg::XY_W-1];
        if ((&top) || !(|top))
        begin
            r = t[dtpc_pkg::XY_W-1:0];
        end
        else if (t[MAG_W])
        begin
            r = dtpc_pkg::XY_MIN;
        end
        else
        begin
            r = dtpc_pkg::XY_MAX;
        end
        return r;
    endfunction

    // position of the incoming pixel and its offsets from the centre
    always_comb
    begin
        w_eff     = eff_dim(fw_reg);
        h_eff     = eff_dim(fh_reg);
        w_ext     = CNT1_W'(w_eff);
        h_ext     = CNT1_W'(h_eff);
        u_inc     = {1'b0, col_reg} + CNT1_W'(1);
        v_inc     = {1'b0, row_reg} + CNT1_W'(1);
        row_end   = (u_inc >= w_ext);
        frame_end = row_end && (v_inc >= h_ext);
        cu        = DIM_W'(w_eff >> 1);
        cv        = DIM_W'(h_eff >> 1);
        neg_x     = (col_reg > cu);
        neg_y     = (row_reg > cv);
        dx        = neg_x ? (col_reg - cu) : (cu - col_reg);
        dy        = neg_y ? (row_reg - cv) : (cv - row_reg);
        if (row_end)
        begin
            col_next = '0;
            row_next = (v_inc >= h_ext) ? '0 : v_inc[DIM_W-1:0];
        end
        else
        begin
            col_next = u_inc[DIM_W-1:0];
            row_next = row_reg;
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.mul_op)
            dtpc_pkg::MUL_ZS:
            begin
                mul_a = MUL_A_W'(z_reg);
                mul_b = MUL_B_W'(scale_reg);
            end
            dtpc_pkg::MUL_XLO:
            begin
                mul_a = MUL_A_W'(zs_reg[LO_W-1:0]);
                mul_b = MUL_B_W'(dx_reg);
            end
            dtpc_pkg::MUL_XHI:
            begin
                mul_a = MUL_A_W'(zs_reg[ZS_W-1:LO_W]);
                mul_b = MUL_B_W'(dx_reg);
            end
            dtpc_pkg::MUL_YLO:
            begin
                mul_a = MUL_A_W'(zs_reg[LO_W-1:0]);
                mul_b = MUL_B_W'(dy_reg);
            end
            dtpc_pkg::MUL_YHI:
            begin
                mul_a = MUL_A_W'(zs_reg[ZS_W-1:LO_W]);
                mul_b = MUL_B_W'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);

    // recombine the two partial products
    assign mag_sum = (MAG_W'(phi_reg) << LO_W) + MAG_W'(plo_reg);

    // control state: configuration, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= dtpc_pkg::RST_FRAME_WIDTH;
            fh_reg        <= dtpc_pkg::RST_FRAME_HEIGHT;
            scale_reg     <= dtpc_pkg::RST_PIXEL_SCALE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dtpc_pkg::CFG_FRAME_WIDTH:
                    begin
                        fw_reg <= cfg_data[dtpc_pkg::CFG_DIM_W-1:0];
                    end
                    dtpc_pkg::CFG_FRAME_HEIGHT:
                    begin
                        fh_reg <= cfg_data[dtpc_pkg::CFG_DIM_W-1:0];
                    end
                    dtpc_pkg::CFG_PIXEL_SCALE:
                    begin
                        scale_reg <= cfg_data[dtpc_pkg::SCALE_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg     <= dtpc_pkg::Z_W'(depth_mm) * dtpc_pkg::Z_W'(dtpc_pkg::UM_PER_MM);
            dx_reg    <= dx;
            dy_reg    <= dy;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            last_reg  <= frame_end;
        end
        case (cmd.mul_op)
            dtpc_pkg::MUL_ZS:
            begin
                zs_reg <= mul_p[ZS_W-1:0];
            end
            dtpc_pkg::MUL_XLO, dtpc_pkg::MUL_YLO:
            begin
                plo_reg <= mul_p[PLO_W-1:0];
            end
            dtpc_pkg::MUL_XHI, dtpc_pkg::MUL_YHI:
            begin
                phi_reg <= mul_p[PHI_W-1:0];
            end
            default:
            begin
            end
        endcase
        if (cmd.sum_x)
        begin
            mag_x_reg <= mag_sum;
        end
        if (cmd.sum_y)
        begin
            mag_y_reg <= mag_sum;
        end
        if (cmd.finish)
        begin
            x_out_reg    <= to_um(mag_x_reg, neg_x_reg);
            y_out_reg    <= to_um(mag_y_reg, neg_y_reg);
            z_out_reg    <= z_reg;
            last_out_reg <= last_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign x_um         = x_out_reg;
    assign y_um         = y_out_reg;
    assign z_um         = z_out_reg;
    assign frame_last   = last_out_reg;

`ifndef ASSERT_OFF
    // a finished point is presented on the next cycle
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished point not presented");

    // the column counter stays inside the row after each pixel
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> ({1'b0, col_reg} < $past(w_ext)))
        else $error("column counter ran past the frame width");

    // the last pixel of a frame returns the raster to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && frame_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("raster did not wrap after the last pixel");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/depth_to_point_cloud.sv
// top level: depth pixel stream to 3d point stream
//
//  channel     dir  handshake           payload
//  depth_in    in   valid/ready         depth_mm[15:0]
//  point_out   out  valid/ready         x_um[35:0] s, y_um[35:0] s, z_um[25:0], frame_last
//  cfg         in   cfg_we, no ready    cfg_index[1:0], cfg_data[23:0]
//
//  each pixel steps through accept, z*scale, two partial products per axis,
//  one recombining sum per axis, and the output load; the single shared
//  multiplier sets this sequence
//  a new request is taken as soon as the previous point sits in the output slot
//  a stall on point_out holds the finished point in the final step
//  reset clears the raster counters and restores the register defaults; no clearing pass
`default_nettype none

module depth_to_point_cloud #(
    parameter int MAX_DIM = dtpc_pkg::DEF_MAX_DIM
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    dtpc_depth_if.sink                            depth_in,
    dtpc_point_if.source                          point_out,
    input  wire logic                             cfg_we,
    input  wire logic [dtpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dtpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dtpc_pkg::cmd_t cmd;
    dtpc_pkg::sts_t sts;
    logic           in_ready;

    // sequencer
    dtpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (depth_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign depth_in.ready = in_ready;

    // datapath
    dtpc_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .depth_mm   (depth_in.depth_mm),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (point_out.ready),
        .out_valid  (point_out.valid),
        .x_um       (point_out.x_um),
        .y_um       (point_out.y_um),
        .z_um       (point_out.z_um),
        .frame_last (point_out.frame_last)
    );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the depth to point cloud converter: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module tb;
    import dtpc_pkg::*;

    localparam int unsigned LONG_ROW     = 540;
    localparam int unsigned PIXEL_TARGET = 550;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 20;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
        logic                   last;
    } point_t;

    typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_DIM_W-1:0] w;
        logic [CFG_DIM_W-1:0] h;
        logic [SCALE_W-1:0]   s;
        logic [DEPTH_W-1:0]   depth;
        bit                   typed;
        point_t               pt;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dtpc_depth_if depth_in ();
    dtpc_point_if point_out ();

    depth_to_point_cloud i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth_in  (depth_in),
        .point_out (point_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the registers and raster counters
    logic [CFG_DIM_W-1:0] cfg_w = RST_FRAME_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_h = RST_FRAME_HEIGHT;
    logic [SCALE_W-1:0]   cfg_s = RST_PIXEL_SCALE;
    logic [10:0]          col_cnt = '0;
    logic [10:0]          row_cnt = '0;

    point_t      pending_points[$];
    dir_row_t    directed_rows[$];
    int unsigned items_sent = 0;
    int unsigned points_checked = 0;
    int unsigned cfg_sets = 0;
    int unsigned frame_ends = 0;
    int unsigned sat_points = 0;
    int unsigned errors = 0;
    int unsigned burst_left = 0;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // frame size as the block uses it
    function automatic int unsigned eff_dim(logic [CFG_DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DEF_MAX_DIM)
            return DEF_MAX_DIM;
        return 32'(d);
    endfunction

    // floor(z * scale * (centre - pos) / 2^frac), saturated to the output range
    function automatic logic signed [XY_W-1:0] project_axis(logic [Z_W-1:0] z,
                                                           int unsigned centre,
                                                           int unsigned pos);
        logic [63:0] mag;
        logic [63:0] q;
        int unsigned offset;
        offset = (pos > centre) ? pos - centre : centre - pos;
        mag = 64'(z) * 64'(cfg_s) * 64'(offset);
        if (pos > centre)
        begin
            q = (mag + ((64'd1 << SCALE_FRAC_BITS) - 64'd1)) >> SCALE_FRAC_BITS;
            if (q > (64'd1 << (XY_W - 1)))
                q = 64'd1 << (XY_W - 1);
            q = 64'd0 - q;
        end
        else
        begin
            q = mag >> SCALE_FRAC_BITS;
            if (q > 64'(XY_MAX))
                q = 64'(XY_MAX);
        end
        return q[XY_W-1:0];
    endfunction

    // expected point for one depth pixel, advances the raster counters
    task automatic predict_point(input logic [DEPTH_W-1:0] d, output point_t pt);
        int unsigned w;
        int unsigned h;
        int unsigned u;
        int unsigned v;
        bit          row_end;
        logic [Z_W-1:0] z;
        w = eff_dim(cfg_w);
        h = eff_dim(cfg_h);
        u = 32'(col_cnt);
        v = 32'(row_cnt);
        z = Z_W'(32'(d) * UM_PER_MM);
        row_end = (u + 1) >= w;
        pt.x = project_axis(z, w / 2, u);
        pt.y = project_axis(z, h / 2, v);
        pt.z = z;
        pt.last = row_end && ((v + 1) >= h);
        if (row_end)
        begin
            col_cnt = '0;
            row_cnt = ((v + 1) >= h) ? 11'd0 : 11'(v + 1);
        end
        else
        begin
            col_cnt = 11'(u + 1);
        end
    endtask

    // write all three registers once the block has drained
    task automatic apply_config(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                                input logic [SCALE_W-1:0] s);
        depth_in.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= CFG_PIXEL_SCALE;
        cfg_data  <= CFG_DATA_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_w = w;
        cfg_h = h;
        cfg_s = s;
        cfg_sets++;
    endtask

    // offer one depth request in bursts with random gaps, record its expected point
    task automatic send_depth(input logic [DEPTH_W-1:0] d, input bit typed, input point_t typed_pt);
        point_t      pt;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                depth_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        depth_in.valid    <= 1'b1;
        depth_in.depth_mm <= d;
        do
            @(posedge clk);
        while (depth_in.ready !== 1'b1);
        predict_point(d, pt);
        pending_points.push_back(typed ? typed_pt : pt);
        items_sent++;
    endtask

    function automatic logic [CFG_DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CFG_DIM_W'($urandom_range(1, 8));
            5:             return $urandom_range(0, 1) ? '0 : CFG_DIM_W'($urandom_range(2049, 4095));
            6:             return CFG_DIM_W'(1);
            7:             return CFG_DIM_W'(DEF_MAX_DIM);
            default:       return CFG_DIM_W'($urandom_range(1, DEF_MAX_DIM));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return '1;
            3, 4, 5: return SCALE_W'($urandom_range(20000, 40000));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DEPTH_W'($urandom_range(1, 255));
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_DIM_W-1:0] w, logic [CFG_DIM_W-1:0] h,
                                         logic [SCALE_W-1:0] s);
        dir_row_t r;
        r = '{kind: ROW_CFG, w: w, h: h, s: s, depth: '0, typed: 1'b0,
              pt: '{'0, '0, '0, 1'b0}};
        return r;
    endfunction

    function automatic dir_row_t pix_row(logic [DEPTH_W-1:0] d);
        dir_row_t r;
        r = '{kind: ROW_PIXEL, w: '0, h: '0, s: '0, depth: d, typed: 1'b0,
              pt: '{'0, '0, '0, 1'b0}};
        return r;
    endfunction

    function automatic dir_row_t chk_row(logic [DEPTH_W-1:0] d, logic signed [XY_W-1:0] x,
                                         logic signed [XY_W-1:0] y, logic [Z_W-1:0] z,
                                         logic last);
        dir_row_t r;
        r = '{kind: ROW_PIXEL, w: '0, h: '0, s: '0, depth: d, typed: 1'b1,
              pt: '{x, y, z, last}};
        return r;
    endfunction

    // stimulus
    initial
    begin
        point_t      blank;
        int unsigned phase;
        int unsigned n;
        blank = '{'0, '0, '0, 1'b0};
        rst_n             <= 1'b0;
        depth_in.valid    <= 1'b0;
        depth_in.depth_mm <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_FRAME_WIDTH;
        cfg_data          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // no reading at reset defaults, then deepest and shallowest
        directed_rows.push_back(chk_row(16'd0, '0, '0, '0, 1'b0));
        directed_rows.push_back(pix_row(16'hFFFF));
        directed_rows.push_back(pix_row(16'd1));
        // shrink to one pixel while the column counter is past the end
        directed_rows.push_back(cfg_row(12'd1, 12'd1, 24'hFFFFFF));
        directed_rows.push_back(pix_row(16'hFFFF));
        directed_rows.push_back(chk_row(16'hFFFF, '0, '0, 26'd65535000, 1'b1));
        // zero size taken as one
        directed_rows.push_back(cfg_row(12'd0, 12'd0, 24'd1234));
        directed_rows.push_back(chk_row(16'd500, '0, '0, 26'd500000, 1'b1));
        // oversized frame clamps to the maximum, corner pixel saturates
        directed_rows.push_back(cfg_row(12'hFFF, 12'hFFF, 24'hFFFFFF));
        directed_rows.push_back(chk_row(16'hFFFF, XY_MAX, XY_MAX, 26'd65535000, 1'b0));
        directed_rows.push_back(chk_row(16'd0, '0, '0, '0, 1'b0));
        // zero scale collapses x and y
        directed_rows.push_back(cfg_row(12'd2048, 12'd2048, 24'd0));
        directed_rows.push_back(chk_row(16'hFFFF, '0, '0, 26'd65535000, 1'b0));
        // small frame, both sides of the centre, bit patterns
        directed_rows.push_back(cfg_row(12'd3, 12'd3, 24'h800000));
        directed_rows.push_back(pix_row(16'hFFFF));
        directed_rows.push_back(pix_row(16'd12345));
        directed_rows.push_back(pix_row(16'd1));
        directed_rows.push_back(pix_row(16'hAAAA));
        directed_rows.push_back(pix_row(16'h5555));
        directed_rows.push_back(pix_row(16'h8000));
        directed_rows.push_back(pix_row(16'h7FFF));
        directed_rows.push_back(pix_row(16'hFFFF));
        directed_rows.push_back(pix_row(16'd40000));
        directed_rows.push_back(pix_row(16'd255));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                apply_config(directed_rows[i].w, directed_rows[i].h, directed_rows[i].s);
            else
                send_depth(directed_rows[i].depth, directed_rows[i].typed, directed_rows[i].pt);
        end

        // random phases, each with its own register setting
        phase = 0;
        while (items_sent < PIXEL_TARGET)
        begin
            if (phase == 1)
            begin
                // a long run of pixels along one wide row, still short of the centre, then a shrink to a
                // tiny frame so the stale column drives x into negative saturation
                apply_config(12'd1, 12'd1, rand_scale());
                send_depth(rand_depth(), 1'b0, blank);
                apply_config(12'd2048, rand_dim(), rand_scale());
                repeat (LONG_ROW) send_depth(rand_depth(), 1'b0, blank);
                apply_config(CFG_DIM_W'($urandom_range(1, 4)), rand_dim(), 24'hFFFFFF);
                send_depth(16'hFFFF, 1'b0, blank);
            end
            else
            begin
                apply_config(rand_dim(), rand_dim(), rand_scale());
            end
            n = $urandom_range(4, 40);
            repeat (n) send_depth(rand_depth(), 1'b0, blank);
            phase++;
        end

        // drain and let any stray point show up
        depth_in.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d depth requests over %0d register settings, %0d points checked",
                 items_sent, cfg_sets, points_checked);
        $display("frame ends seen %0d, saturated points seen %0d, mismatches %0d",
                 frame_ends, sat_points, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: rotating stall patterns plus one long hold while requests keep coming
    initial
    begin
        int unsigned rx_cycle;
        int unsigned rx_mode;
        bit          hold_done;
        rx_cycle  = 0;
        hold_done = 1'b0;
        point_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!hold_done && points_checked >= 200 && depth_in.valid === 1'b1)
            begin
                hold_done = 1'b1;
                point_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rx_mode = (rx_cycle / 64) % 4;
                case (rx_mode)
                    0:       point_out.ready <= 1'b1;
                    1:       point_out.ready <= ($urandom_range(0, 3) != 0);
                    2:       point_out.ready <= ($urandom_range(0, 3) == 0);
                    default: point_out.ready <= rx_cycle[2];
                endcase
            end
        end
    end

    // scoreboard: compare each accepted point with the oldest expectation
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n === 1'b1 && point_out.valid === 1'b1 && point_out.ready === 1'b1)
        begin
            points_checked++;
            if (point_out.frame_last === 1'b1)
                frame_ends++;
            if (point_out.x_um === XY_MAX || point_out.x_um === XY_MIN ||
                point_out.y_um === XY_MAX || point_out.y_um === XY_MIN)
                sat_points++;
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d last=%0b",
                         $time, point_out.x_um, point_out.y_um, point_out.z_um,
                         point_out.frame_last);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_out.x_um !== want.x)
                begin
                    $display("%0t: x_um mismatch, expected %0d, actual %0d",
                             $time, want.x, point_out.x_um);
                    errors++;
                end
                if (point_out.y_um !== want.y)
                begin
                    $display("%0t: y_um mismatch, expected %0d, actual %0d",
                             $time, want.y, point_out.y_um);
                    errors++;
                end
                if (point_out.z_um !== want.z)
                begin
                    $display("%0t: z_um mismatch, expected %0d, actual %0d",
                             $time, want.z, point_out.z_um);
                    errors++;
                end
                if (point_out.frame_last !== want.last)
                begin
                    $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                             $time, want.last, point_out.frame_last);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("timeout with %0d points outstanding", pending_points.size());
        $display("FAIL");
        $finish;
    end

endmodule
